@@ rtl/smf_pkg.sv @@
// ----------------------------------------------------------------------------
// smf_pkg: shared types and constants of the sliding median / center mean filter
// Field widths, register indexes, reset values and state encodings.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int WINDOW_MAX_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int WINDOW_MIN      = 3;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 5;
  localparam int WS_W        = 5;
  localparam int EVEN_W      = 5;
  localparam int ODD_W       = 4;

  // result field
  localparam int FILL_FIELD_W = 5;

  localparam logic [WS_W-1:0]   WINDOW_SIZE_RST = WS_W'(15);
  localparam logic [EVEN_W-1:0] EVEN_COUNT_RST  = EVEN_W'(2);
  localparam logic [ODD_W-1:0]  ODD_COUNT_RST   = ODD_W'(3);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WINDOW_SIZE = 2'd0,
    REG_EVEN_COUNT  = 2'd1,
    REG_ODD_COUNT   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_SETUP,
    TOP_CALC,
    TOP_HOLD
  } top_state_t;

  typedef enum logic [1:0] {
    MEAN_IDLE,
    MEAN_SUM,
    MEAN_DIV
  } mean_state_t;

  // update command broadcast to every sorted cell
  typedef struct packed {
    logic load;   // take the new ordering this cycle
    logic drop;   // window full: the oldest word leaves
  } cell_ctl_t;

endpackage

@@ rtl/smf_cell.sv @@
// ----------------------------------------------------------------------------
// smf_cell: one slot of the sorted insertion chain
// Holds one sorted word; removes the leaving word and inserts the new one
// in the same update, looking only at its two neighbors.
// ----------------------------------------------------------------------------
module smf_cell
  import smf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  cell_ctl_t                     ctl,
  input  logic                          live,        // slot index below length after removal
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [SAMPLE_BITS-1:0] old_value,
  input  logic signed [SAMPLE_BITS-1:0] right_value,
  input  logic signed [SAMPLE_BITS-1:0] left_r,
  input  logic                          left_le,
  output logic signed [SAMPLE_BITS-1:0] value,
  output logic signed [SAMPLE_BITS-1:0] r_out,
  output logic                          le_out
);

  logic                          keep;
  logic signed [SAMPLE_BITS-1:0] r_here;
  logic signed [SAMPLE_BITS-1:0] value_next;

  // slots below the first copy of the leaving word stay, the rest close the gap
  assign keep   = value < old_value;
  assign r_here = (ctl.drop && !keep) ? right_value : value;
  assign r_out  = r_here;
  assign le_out = live && (r_here <= sample);

  always_comb begin
    if (le_out) begin
      value_next = r_here;
    end else if (left_le) begin
      value_next = sample;
    end else begin
      value_next = left_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      value <= value_next;
    end
  end

endmodule

@@ rtl/smf_mean.sv @@
// ----------------------------------------------------------------------------
// smf_mean: center span mean
// Sums the span one sorted word per cycle, then divides by the span length
// with a restoring divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module smf_mean
  import smf_pkg::*;
#(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int IDX_W  = $clog2(WINDOW_MAX),
  localparam int FILL_W = $clog2(WINDOW_MAX + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [IDX_W-1:0]              span_first,
  input  logic [FILL_W-1:0]             span_len,
  input  logic signed [SAMPLE_BITS-1:0] elem,
  output logic [IDX_W-1:0]              elem_index,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] mean
);

  localparam int SUM_W  = SAMPLE_BITS + FILL_W + 1;
  localparam int STEP_W = $clog2(SUM_W + 1);

  mean_state_t state, state_next;

  logic signed [SUM_W-1:0]  acc;
  logic [IDX_W-1:0]         idx;
  logic [FILL_W-1:0]        left;
  logic [FILL_W-1:0]        divisor;
  logic [SUM_W-1:0]         quo;
  logic [FILL_W-1:0]        rem;
  logic                     neg;
  logic [STEP_W-1:0]        step;

  logic signed [SUM_W-1:0]  sum_next;
  logic [SUM_W-1:0]         mag;
  logic [FILL_W:0]          sh;
  logic [FILL_W:0]          diff;
  logic                     ge;
  logic [SUM_W-1:0]         q_final;
  logic [SUM_W-1:0]         q_signed;
  logic                     last_add;
  logic                     last_step;

  assign elem_index = idx;
  assign sum_next   = acc + SUM_W'(elem);
  assign mag        = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
  assign sh         = {rem, quo[SUM_W-1]};
  assign diff       = sh - {1'b0, divisor};
  assign ge         = sh >= {1'b0, divisor};
  assign q_final    = {quo[SUM_W-2:0], ge};
  assign q_signed   = neg ? (~q_final + SUM_W'(1)) : q_final;
  assign last_add   = left == FILL_W'(1);
  assign last_step  = step == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MEAN_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      MEAN_IDLE: if (start)     state_next = MEAN_SUM;
      MEAN_SUM:  if (last_add)  state_next = MEAN_DIV;
      MEAN_DIV:  if (last_step) state_next = MEAN_IDLE;
      default:                  state_next = MEAN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == MEAN_DIV) && last_step;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      MEAN_IDLE: begin
        if (start) begin
          acc     <= '0;
          idx     <= span_first;
          left    <= span_len;
          divisor <= span_len;
        end
      end
      MEAN_SUM: begin
        acc  <= sum_next;
        idx  <= idx + IDX_W'(1);
        left <= left - FILL_W'(1);
        if (last_add) begin
          quo  <= mag;
          neg  <= sum_next[SUM_W-1];
          rem  <= '0;
          step <= STEP_W'(SUM_W - 1);
        end
      end
      MEAN_DIV: begin
        quo  <= q_final;
        rem  <= ge ? diff[FILL_W-1:0] : sh[FILL_W-1:0];
        step <= step - STEP_W'(1);
        if (last_step) begin
          mean <= q_signed[SAMPLE_BITS-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/sliding_median_center_mean_filter.sv @@
// ----------------------------------------------------------------------------
// sliding_median_center_mean_filter: sliding window center mean filter
// Keeps the latest samples in a sorted chain and returns the mean of the
// sorted words around the middle together with the window fill.
// ----------------------------------------------------------------------------
// One result word per input word. A sample enters the sorted cell chain as
// it is accepted (the oldest sample leaves at the same time once the window
// is full); then a setup state starts the mean unit, which sums the center
// span one sorted word per cycle and runs the restoring divider over
// SAMPLE_BITS + clog2(WINDOW_MAX+1) + 1 quotient bits (22 at the defaults);
// its done flag is registered, and then the output register is loaded.
// The next sample is taken as soon as the result sits in the output register;
// a word still waiting there holds the new result, and with it the input,
// back until it is taken.
// Writing window_size empties the window.
module sliding_median_center_mean_filter
  import smf_pkg::*;
#(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((SAMPLE_BITS + FILL_FIELD_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_W-1:0]        s_axis_tdata,   // sample
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_W-1:0]       m_axis_tdata,   // filtered_value, fill_count
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W  = $clog2(WINDOW_MAX);
  localparam int FILL_W = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W  = (FILL_W > WS_W) ? FILL_W : WS_W;

  top_state_t state, state_next;

  logic [WS_W-1:0]   window_size;
  logic [EVEN_W-1:0] even_center_count;
  logic [ODD_W-1:0]  odd_center_count;

  logic [FILL_W-1:0] fill;
  logic [IDX_W-1:0]  ptr;
  logic signed [SAMPLE_BITS-1:0] arrival [WINDOW_MAX];

  logic signed [SAMPLE_BITS-1:0] out_value;
  logic [FILL_W-1:0]             out_fill;

  logic                          accept;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic signed [SAMPLE_BITS-1:0] old_value;
  logic [CMP_W-1:0]              ws_ext;
  logic [FILL_W-1:0]             w_eff;
  logic                          full;
  logic [FILL_W-1:0]             rlen;
  cell_ctl_t                     ctl;

  logic signed [SAMPLE_BITS-1:0] sorted_q [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] r_chain  [WINDOW_MAX];
  logic                          le_chain [WINDOW_MAX];

  logic [CMP_W-1:0]              cnt_sel;
  logic [FILL_W-1:0]             span_len;
  logic [IDX_W-1:0]              span_first;
  logic                          mean_start;
  logic [IDX_W-1:0]              elem_index;
  logic                          mean_done;
  logic signed [SAMPLE_BITS-1:0] mean;
  logic                          out_free;

  assign sample    = s_axis_tdata[SAMPLE_BITS-1:0];
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign old_value = arrival[ptr];

  // window size clamped to the legal range
  assign ws_ext = CMP_W'(window_size);
  always_comb begin
    if (ws_ext < CMP_W'(WINDOW_MIN)) begin
      w_eff = FILL_W'(WINDOW_MIN);
    end else if (ws_ext > CMP_W'(WINDOW_MAX)) begin
      w_eff = FILL_W'(WINDOW_MAX);
    end else begin
      w_eff = FILL_W'(ws_ext);
    end
  end

  assign full     = fill >= w_eff;
  assign rlen     = full ? fill - FILL_W'(1) : fill;
  assign ctl.load = accept;
  assign ctl.drop = full;

  // sorted cell chain
  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] right_value;
    logic signed [SAMPLE_BITS-1:0] left_r;
    logic                          left_le;

    if (k == WINDOW_MAX - 1) begin : g_last
      assign right_value = sorted_q[k];
    end else begin : g_mid
      assign right_value = sorted_q[k+1];
    end

    if (k == 0) begin : g_first
      assign left_r  = sample;
      assign left_le = 1'b1;
    end else begin : g_rest
      assign left_r  = r_chain[k-1];
      assign left_le = le_chain[k-1];
    end

    smf_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .live       (FILL_W'(k) < rlen),
      .sample     (sample),
      .old_value  (old_value),
      .right_value(right_value),
      .left_r     (left_r),
      .left_le    (left_le),
      .value      (sorted_q[k]),
      .r_out      (r_chain[k]),
      .le_out     (le_chain[k])
    );
  end

  // arrival ring: ptr is the next free slot while filling, the oldest once full
  always_ff @(posedge clk) begin
    if (accept) begin
      arrival[ptr] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size       <= WINDOW_SIZE_RST;
      even_center_count <= EVEN_COUNT_RST;
      odd_center_count  <= ODD_COUNT_RST;
      fill              <= '0;
      ptr               <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WINDOW_SIZE: begin
          window_size <= cfg_data[WS_W-1:0];
          fill        <= '0;
          ptr         <= '0;
        end
        REG_EVEN_COUNT: even_center_count <= cfg_data[EVEN_W-1:0];
        REG_ODD_COUNT:  odd_center_count  <= cfg_data[ODD_W-1:0];
        default: begin
        end
      endcase
    end else if (accept) begin
      if (!full) begin
        fill <= fill + FILL_W'(1);
      end
      if (FILL_W'(ptr) + FILL_W'(1) == w_eff) begin
        ptr <= '0;
      end else begin
        ptr <= ptr + IDX_W'(1);
      end
    end
  end

  // center span from the updated fill
  always_comb begin
    cnt_sel = fill[0] ? CMP_W'(odd_center_count) : CMP_W'(even_center_count);
    if (cnt_sel == '0) begin
      span_len = FILL_W'(1);
    end else if (cnt_sel > CMP_W'(fill)) begin
      span_len = fill;
    end else begin
      span_len = FILL_W'(cnt_sel);
    end
    span_first = IDX_W'((fill >> 1) - (span_len >> 1));
  end

  smf_mean #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_mean (
    .clk       (clk),
    .rst       (rst),
    .start     (mean_start),
    .span_first(span_first),
    .span_len  (span_len),
    .elem      (sorted_q[elem_index]),
    .elem_index(elem_index),
    .done      (mean_done),
    .mean      (mean)
  );

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TOP_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    mean_start    = 1'b0;
    case (state)
      TOP_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_next = TOP_SETUP;
      end
      TOP_SETUP: begin
        mean_start = 1'b1;
        state_next = TOP_CALC;
      end
      TOP_CALC: if (mean_done) state_next = TOP_HOLD;
      TOP_HOLD: if (out_free)  state_next = TOP_IDLE;
      default:                 state_next = TOP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == TOP_HOLD && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == TOP_HOLD && out_free) begin
      out_value <= mean;
      out_fill  <= fill;
    end
  end

  assign m_axis_tdata = OUT_W'({FILL_FIELD_W'(out_fill), out_value});

endmodule
